>>> hw/rtl/obdil_pkg.sv
// Shared types and constants for the obstacle dilation block.
// No dependencies; every other file imports this package.
`default_nettype none

package obdil_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int MAX_RADIUS  = 7;
  localparam int STORE_ROWS  = 2 * MAX_RADIUS;
  localparam int LANES       = MAX_RADIUS + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int RAD_W     = 3;
  localparam int PIX_W     = 8;
  localparam int OUT_POS_W = 10;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SLOT_W = $clog2(STORE_ROWS);
  localparam int LANE_W = $clog2(LANES);
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 1024;
  localparam int RADIUS_RESET = 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_INFLATE_RADIUS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_UPD,
    B_EMIT
  } back_state_t;

  // one classified pixel, handed from front to back
  typedef struct packed {
    logic [LANES-1:0][STORE_ROWS-1:0] mask;
    logic [COL_W-1:0]                 col;
    logic [COL_W-1:0]                 col_lo;
    logic [COL_W-1:0]                 col_hi;
    logic [ROW_W-1:0]                 row_base;
    logic [LANE_W-1:0]                lane_last;
    logic [SLOT_W-1:0]                slot;
    logic [RAD_W-1:0]                 radius;
    logic                             obst;
    logic                             emit;
    logic                             row_last;
    logic                             col_last;
  } obdil_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/obdil_front.sv
// Front end: configuration registers, raster position and pixel classification.
// Depends on obdil_pkg; feeds obdil_queue.
`default_nettype none

module obdil_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [obdil_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [obdil_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [obdil_pkg::PIX_W-1:0]   in_pixel_value,
  output logic                          item_valid,
  input  logic                          item_ready,
  output obdil_pkg::obdil_item_t        item
);
  import obdil_pkg::*;

  logic [CFG_W-1:0]  width_r, width_nxt;
  logic [CFG_W-1:0]  height_r, height_nxt;
  logic [RAD_W-1:0]  radius_r, radius_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              cfg_restart;
  logic              accept;

  logic [COL_W-1:0]  w_last;
  logic [ROW_W-1:0]  h_last;
  logic [RAD_W-1:0]  rad;
  logic [RAD_W-1:0]  q;
  logic              row_last, col_last, row_ge, col_ge;
  logic [COL_W-1:0]  col_lo;
  logic [SLOT_W-1:0] ring_gap [STORE_ROWS];
  logic [SLOT_W-1:0] reach [LANES];
  logic [SLOT_W-1:0] span [LANES];
  logic              lane_on [LANES];

  assign in_ready   = item_ready;
  assign item_valid = in_valid;
  assign accept     = in_valid && item_ready;

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    radius_nxt  = radius_r;
    cfg_restart = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          width_nxt   = cfg_data;
          cfg_restart = 1'b1;
        end
        CFG_FRAME_HEIGHT: begin
          height_nxt  = cfg_data;
          cfg_restart = 1'b1;
        end
        CFG_INFLATE_RADIUS: begin
          radius_nxt  = cfg_data[RAD_W-1:0];
          cfg_restart = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_last = '0;
    end else if (width_r > CFG_W'(MAX_WIDTH)) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(width_r - CFG_W'(1));
    end
    if (height_r == '0) begin
      h_last = '0;
    end else if (height_r > CFG_W'(MAX_HEIGHT)) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(height_r - CFG_W'(1));
    end
    rad = (radius_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_r;
  end

  always_comb begin
    row_last = (row_r == h_last);
    col_last = (col_r == w_last);
    row_ge   = (row_r >= ROW_W'(rad));
    col_ge   = (col_r >= COL_W'(rad));
    q        = row_ge ? rad : row_r[RAD_W-1:0];
    col_lo   = col_ge ? (col_r - COL_W'(rad)) : '0;
  end

  // ring distance from the current row's slot back to slot t
  always_comb begin
    for (int t = 0; t < STORE_ROWS; t++) begin
      if (slot_r >= SLOT_W'(t)) begin
        ring_gap[t] = slot_r - SLOT_W'(t);
      end else begin
        ring_gap[t] = slot_r + SLOT_W'(STORE_ROWS - t);
      end
    end
  end

  // per output row lane: how many rows back its window reaches
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_on[k] = (rad != '0) && (LANE_W'(k) <= LANE_W'(q));
      span[k]    = SLOT_W'(q) - SLOT_W'(k) + SLOT_W'(rad) - SLOT_W'(1);
      reach[k]   = (ROW_W'(span[k]) > row_r) ? row_r[SLOT_W-1:0] : span[k];
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      for (int t = 0; t < STORE_ROWS; t++) begin
        item.mask[k][t] = lane_on[k] && (ring_gap[t] <= reach[k]);
      end
    end
    item.col       = col_r;
    item.col_lo    = col_lo;
    item.col_hi    = col_last ? col_r : col_lo;
    item.row_base  = row_r - ROW_W'(q);
    item.lane_last = row_last ? LANE_W'(q) : '0;
    item.slot      = slot_r;
    item.radius    = rad;
    item.obst      = (in_pixel_value == '0);
    item.emit      = (row_last || row_ge) && (col_last || col_ge);
    item.row_last  = row_last;
    item.col_last  = col_last;
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    if (cfg_restart) begin
      row_nxt  = '0;
      col_nxt  = '0;
      slot_nxt = '0;
    end else if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_r + ROW_W'(1);
          slot_nxt = (slot_r == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_r + SLOT_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(WIDTH_RESET);
      height_r <= CFG_W'(HEIGHT_RESET);
      radius_r <= RAD_W'(RADIUS_RESET);
      row_r    <= '0;
      col_r    <= '0;
      slot_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      radius_r <= radius_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      slot_r   <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/obdil_queue.sv
// Short word queue between front and back.
// Depends on obdil_pkg.
`default_nettype none

module obdil_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  obdil_pkg::obdil_item_t push_item,
  output logic                   pop_valid,
  input  logic                   pop,
  output obdil_pkg::obdil_item_t pop_item
);
  import obdil_pkg::*;

  obdil_item_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/obdil_back.sv
// Back end: line store, per-row horizontal trackers and result sequencing.
// Depends on obdil_pkg; takes words from obdil_queue.
`default_nettype none

module obdil_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  obdil_pkg::obdil_item_t         q_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [obdil_pkg::OUT_POS_W-1:0] out_row,
  output logic [obdil_pkg::OUT_POS_W-1:0] out_col,
  output logic                           out_occupied,
  output logic                           out_burst_last,
  output logic                           out_frame_done
);
  import obdil_pkg::*;

  back_state_t             state_r, state_nxt;
  obdil_item_t             cur_r;
  logic                    store_mem [STORE_ROWS][MAX_WIDTH];
  logic [STORE_ROWS-1:0]   rd_r;
  logic [STORE_ROWS-1:0]   col_word;
  logic [LANES-1:0]        lane_hit;
  logic [LANES-1:0]        hit_valid_r;
  logic [COL_W-1:0]        last_hit_r [LANES];
  logic [LANE_W-1:0]       lane_r;
  logic [COL_W-1:0]        col_r;
  logic                    issue, emit_fire, at_end, occ;

  logic                    out_valid_r;
  logic [OUT_POS_W-1:0]    out_row_r, out_col_r;
  logic                    out_occupied_r, out_burst_last_r, out_frame_done_r;

  // fetch: write the pixel bit and read its column from every ring row
  always_ff @(posedge clk) begin
    for (int s = 0; s < STORE_ROWS; s++) begin
      if (issue && q_item.slot == SLOT_W'(s)) begin
        store_mem[s][q_item.col] <= q_item.obst;
      end
      if (issue) begin
        rd_r[s] <= store_mem[s][q_item.col];
      end
    end
  end

  always_comb begin
    col_word = rd_r;
    col_word[cur_r.slot] = cur_r.obst;
    for (int k = 0; k < LANES; k++) begin
      lane_hit[k] = |(col_word & cur_r.mask[k]);
    end
  end

  always_comb begin
    emit_fire = (state_r == B_EMIT) && (!out_valid_r || out_ready);
    at_end    = (col_r == cur_r.col_hi) && (lane_r == cur_r.lane_last);
    unique case (state_r)
      B_IDLE:  issue = q_valid;
      B_UPD:   issue = !cur_r.emit && q_valid;
      B_EMIT:  issue = emit_fire && at_end && q_valid;
      default: issue = 1'b0;
    endcase
  end

  always_comb begin
    unique case (state_r)
      B_IDLE: begin
        state_nxt = q_valid ? B_UPD : B_IDLE;
      end
      B_UPD: begin
        if (cur_r.emit) begin
          state_nxt = B_EMIT;
        end else begin
          state_nxt = q_valid ? B_UPD : B_IDLE;
        end
      end
      B_EMIT: begin
        if (emit_fire && at_end) begin
          state_nxt = q_valid ? B_UPD : B_IDLE;
        end else begin
          state_nxt = B_EMIT;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign q_pop = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cur_r <= q_item;
    end
  end

  // track the newest obstacle column of each output row along the input row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_valid_r <= '0;
    end else if (state_r == B_UPD) begin
      for (int k = 0; k < LANES; k++) begin
        if (lane_hit[k]) begin
          hit_valid_r[k] <= 1'b1;
        end else if (cur_r.col == '0) begin
          hit_valid_r[k] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (state_r == B_UPD && lane_hit[k]) begin
        last_hit_r[k] <= cur_r.col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= '0;
      col_r  <= '0;
    end else if (state_r == B_UPD) begin
      lane_r <= '0;
      col_r  <= cur_r.col_lo;
    end else if (emit_fire) begin
      if (col_r == cur_r.col_hi) begin
        col_r  <= cur_r.col_lo;
        lane_r <= lane_r + LANE_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  assign occ = hit_valid_r[lane_r] &&
               (({1'b0, last_hit_r[lane_r]} + (COL_W+1)'(cur_r.radius)) > {1'b0, col_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_row_r        <= OUT_POS_W'(cur_r.row_base + ROW_W'(lane_r));
      out_col_r        <= OUT_POS_W'(col_r);
      out_occupied_r   <= occ;
      out_burst_last_r <= at_end;
      out_frame_done_r <= at_end && cur_r.row_last && cur_r.col_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_occupied   = out_occupied_r;
  assign out_burst_last = out_burst_last_r;
  assign out_frame_done = out_frame_done_r;

  a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT |-> cur_r.emit)
    else $error("emit state entered for a word with no results");

  a_lane_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT |-> lane_r <= cur_r.lane_last)
    else $error("lane counter ran past the last output row");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_upd_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_UPD |-> $past(q_pop))
    else $error("tracker update without a fetched word");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_done_r |-> out_burst_last_r)
    else $error("frame end flagged on a non-final result");

endmodule

`default_nettype wire

>>> hw/rtl/binary_obstacle_dilation.sv
// Streaming obstacle dilation over raster map pixels; a red byte of 0 marks an obstacle.
// Depends on obdil_pkg, obdil_front, obdil_queue and obdil_back.
//
// Each accepted pixel is fetched from the queue together with its column from the
// 14-row line store, both registered, and then updates the per-row trackers; after
// that the back end releases the pixel's results through the output register, one
// per cycle while the output is not stalled. A pixel releases none, one, or, at a
// row end or at the frame end, a burst of results. A two-word queue lets the front
// keep taking pixels while the back drains a burst. The line store needs no clearing
// pass: only entries written in the current frame are read. Any register write
// restarts the frame at row 0, column 0.
`default_nettype none

module binary_obstacle_dilation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [obdil_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [obdil_pkg::CFG_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [obdil_pkg::PIX_W-1:0]    in_pixel_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [obdil_pkg::OUT_POS_W-1:0] out_row,
  output logic [obdil_pkg::OUT_POS_W-1:0] out_col,
  output logic                           out_occupied,
  output logic                           out_burst_last,
  output logic                           out_frame_done
);
  import obdil_pkg::*;

  obdil_item_t front_item;
  obdil_item_t queue_item;
  logic        front_valid, front_ready;
  logic        queue_valid, queue_pop;

  obdil_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .item_valid     (front_valid),
    .item_ready     (front_ready),
    .item           (front_item)
  );

  obdil_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop        (queue_pop),
    .pop_item   (queue_item)
  );

  obdil_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (queue_valid),
    .q_pop          (queue_pop),
    .q_item         (queue_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_occupied   (out_occupied),
    .out_burst_last (out_burst_last),
    .out_frame_done (out_frame_done)
  );

endmodule

`default_nettype wire
